FILE: hw/rtl/met_pkg.sv
// Shared types, register codes and fixed-point helpers for the escape-time block.
package met_pkg;

	localparam int OUT_LANES = 4;
	localparam int LANE_W    = $clog2(OUT_LANES);
	localparam int THR_W     = 31;
	localparam int ITER_W    = 16;
	localparam int CNT_W     = 8;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_RE_MIN    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IM_MIN    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_RE   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_IM   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ITERS = 3'd5;

	localparam logic signed [31:0] RST_RE_MIN    = -32'sd536870912;
	localparam logic signed [31:0] RST_IM_MIN    = -32'sd268435456;
	localparam logic signed [31:0] RST_STEP_RE   = 32'sd262144;
	localparam logic signed [31:0] RST_STEP_IM   = 32'sd262144;
	localparam logic [THR_W-1:0]   RST_THRESHOLD = 31'd1073741824;
	localparam logic [ITER_W-1:0]  RST_MAX_ITERS = 16'd255;

	typedef struct packed {
		logic [9:0]  col_group;
		logic [11:0] row;
	} met_in_t;

	typedef struct packed {
		logic [CNT_W-1:0] count0;
		logic [CNT_W-1:0] count1;
		logic [CNT_W-1:0] count2;
		logic [CNT_W-1:0] count3;
	} met_out_t;

	typedef struct packed {
		logic signed [31:0] re_min;
		logic signed [31:0] im_min;
		logic signed [31:0] step_re;
		logic signed [31:0] step_im;
		logic [THR_W-1:0]   threshold;
		logic [ITER_W-1:0]  max_iters;
	} met_cfg_t;

	// Clamp to the signed 32-bit range.
	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (v < -64'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

FILE: hw/rtl/met_cfg.sv
// Configuration register file for the escape-time block.
module met_cfg
	import met_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [31:0]          wr_data,
	output met_cfg_t             regs
);

	met_cfg_t regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.re_min    <= RST_RE_MIN;
			regs_q.im_min    <= RST_IM_MIN;
			regs_q.step_re   <= RST_STEP_RE;
			regs_q.step_im   <= RST_STEP_IM;
			regs_q.threshold <= RST_THRESHOLD;
			regs_q.max_iters <= RST_MAX_ITERS;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_RE_MIN:    regs_q.re_min    <= $signed(wr_data);
				REG_IM_MIN:    regs_q.im_min    <= $signed(wr_data);
				REG_STEP_RE:   regs_q.step_re   <= $signed(wr_data);
				REG_STEP_IM:   regs_q.step_im   <= $signed(wr_data);
				REG_THRESHOLD: regs_q.threshold <= wr_data[THR_W-1:0];
				REG_MAX_ITERS: regs_q.max_iters <= wr_data[ITER_W-1:0];
				default: ;
			endcase
		end
	end

	assign regs = regs_q;

endmodule

FILE: hw/rtl/met_mul.sv
// Shared signed 32x32 multiplier with a registered 64-bit product.
module met_mul
	import met_pkg::*;
(
	input  logic               clk,
	input  logic signed [31:0] a,
	input  logic signed [31:0] b,
	output logic signed [63:0] p
);

	logic signed [63:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= 64'(a) * 64'(b);
	end

	assign p = p_q;

endmodule

FILE: hw/rtl/mandelbrot_escape_time_4lane.sv
// Escape-time counter for four adjacent pixels on one shared multiplier.
//
//   channel | signals                              | direction | beat
//   input   | in_valid, in_stall, in_data          | in        | one pixel group
//   output  | out_valid, out_stall, out_data       | out       | four lane counts
//   config  | cfg_valid, cfg_ready, cfg_index/data | in        | one register write
//
// A group is worked from acceptance to out_valid as: the row product, then for each lane
// the column product and n_k steps, n_k being the steps lane k evaluates, the escaping one
// included (at most max_iters); each step is three products through the one multiplier
// and the compare, and the lanes are worked one after another. The next group is
// accepted only once the sequencer is back in idle.
// Reset clears the sequencer, output valid and the configuration registers to their defaults.
// in_stall is high from acceptance until the result is loaded into the output
// register; a held result only delays the load of the next one.
module mandelbrot_escape_time_4lane
	import met_pkg::*;
#(
	parameter int FRAC_BITS = 28
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  met_in_t              in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output met_out_t             out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data
);

	localparam int COL_W = $clog2(OUT_LANES * 1024 + OUT_LANES);
	localparam int SQ_W  = 63 - FRAC_BITS;
	localparam int CMP_W = (SQ_W + 1 > THR_W) ? SQ_W + 1 : THR_W;

	localparam logic [3:0] ST_IDLE    = 4'd0;
	localparam logic [3:0] ST_CIM_MUL = 4'd1;
	localparam logic [3:0] ST_CIM     = 4'd2;
	localparam logic [3:0] ST_CRE_MUL = 4'd3;
	localparam logic [3:0] ST_CRE     = 4'd4;
	localparam logic [3:0] ST_XY      = 4'd5;
	localparam logic [3:0] ST_TI      = 4'd6;
	localparam logic [3:0] ST_SQI     = 4'd7;
	localparam logic [3:0] ST_CMP     = 4'd8;
	localparam logic [3:0] ST_LANE    = 4'd9;
	localparam logic [3:0] ST_OUT     = 4'd10;

	met_cfg_t cfg;

	logic [3:0]        state_q;
	logic [LANE_W-1:0] lane_q;
	logic              out_valid_q;
	met_out_t          out_q;
	met_in_t           in_q;

	logic signed [31:0] cim_q, cre_q, xr_q, xi_q, sqr_q, sqi_q, tr_q, ti_q;
	logic [SQ_W-1:0]    rr_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [ITER_W-1:0]  it_q;
	logic [CNT_W-1:0]   counts_q [OUT_LANES];

	logic signed [31:0] mul_a, mul_b;
	logic signed [63:0] prod;
	logic signed [63:0] prod_fx;
	logic [COL_W-1:0]   col;
	logic signed [31:0] tr_next, ti_next, xy_s, diff_s, sqi_next;
	logic [SQ_W:0]      mag;
	logic               pass;
	logic               last_iter;
	logic               out_load;

	met_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.regs     (cfg)
	);

	met_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (prod)
	);

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign col = COL_W'(in_q.col_group) * COL_W'(OUT_LANES) + COL_W'(lane_q);

	// Arithmetic shift of the product floors it.
	assign prod_fx = prod >>> FRAC_BITS;

	assign diff_s   = sat32(64'(sqr_q) - 64'(sqi_q));
	assign tr_next  = sat32(64'(diff_s) + 64'(cre_q));
	assign xy_s     = sat32(prod_fx);
	assign ti_next  = sat32(64'(sat32(64'(xy_s) <<< 1)) + 64'(cim_q));
	assign sqi_next = sat32(prod_fx);

	assign mag       = {1'b0, rr_q} + {1'b0, prod_fx[SQ_W-1:0]};
	assign pass      = CMP_W'(mag) < CMP_W'(cfg.threshold);
	assign last_iter = (it_q + 16'd1) == cfg.max_iters;
	assign out_load  = !out_valid_q || !out_stall;

	always_comb begin
		unique case (state_q)
			ST_CIM_MUL: begin
				mul_a = cfg.step_im;
				mul_b = $signed(32'(in_q.row));
			end
			ST_CRE_MUL: begin
				mul_a = cfg.step_re;
				mul_b = $signed(32'(col));
			end
			ST_XY: begin
				mul_a = xr_q;
				mul_b = xi_q;
			end
			ST_TI: begin
				mul_a = tr_q;
				mul_b = tr_q;
			end
			ST_SQI: begin
				mul_a = ti_q;
				mul_b = ti_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Sequencer and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			lane_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_OUT && out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						lane_q  <= '0;
						state_q <= ST_CIM_MUL;
					end
				end
				ST_CIM_MUL: state_q <= ST_CIM;
				ST_CIM:     state_q <= ST_CRE_MUL;
				ST_CRE_MUL: state_q <= ST_CRE;
				ST_CRE: begin
					state_q <= (cfg.max_iters == '0) ? ST_LANE : ST_XY;
				end
				ST_XY:  state_q <= ST_TI;
				ST_TI:  state_q <= ST_SQI;
				ST_SQI: state_q <= ST_CMP;
				ST_CMP: begin
					state_q <= (pass && !last_iter) ? ST_XY : ST_LANE;
				end
				ST_LANE: begin
					if (lane_q == LANE_W'(OUT_LANES - 1)) begin
						state_q <= ST_OUT;
					end else begin
						lane_q  <= lane_q + 1'b1;
						state_q <= ST_CRE_MUL;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					in_q <= in_data;
				end
			end
			ST_CIM: cim_q <= sat32(64'(cfg.im_min) + prod);
			ST_CRE: begin
				cre_q <= sat32(64'(cfg.re_min) + prod);
				xr_q  <= '0;
				xi_q  <= '0;
				sqr_q <= '0;
				sqi_q <= '0;
				it_q  <= '0;
				cnt_q <= '0;
			end
			ST_XY:  tr_q <= tr_next;
			ST_TI:  ti_q <= ti_next;
			ST_SQI: rr_q <= prod_fx[SQ_W-1:0];
			ST_CMP: begin
				if (pass) begin
					cnt_q <= cnt_q + 1'b1;
					it_q  <= it_q + 1'b1;
					xr_q  <= tr_q;
					xi_q  <= ti_q;
					sqr_q <= sat32($signed(64'(rr_q)));
					sqi_q <= sqi_next;
				end
			end
			ST_LANE: counts_q[lane_q] <= cnt_q;
			ST_OUT: begin
				if (out_load) begin
					out_q.count0 <= counts_q[0];
					out_q.count1 <= counts_q[1];
					out_q.count2 <= counts_q[2];
					out_q.count3 <= counts_q[3];
				end
			end
			default: ;
		endcase
	end

endmodule

FILE: tb/sv/mandelbrot_escape_time_4lane_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the four-lane escape-time counter with its own count predictor.
module mandelbrot_escape_time_4lane_test
	import met_pkg::*;
();

	localparam int FRAC = 28;
	localparam int ONE  = 1 << FRAC;
	localparam longint S32_HI = 64'sd2147483647;
	localparam longint S32_LO = -S32_HI - 1;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

	class lane_count_book;
		longint re0, im0, dre, dim, thr;
		int unsigned limit;
		met_out_t pending[$];
		int errors;

		function new();
			re0 = longint'(RST_RE_MIN);
			im0 = longint'(RST_IM_MIN);
			dre = longint'(RST_STEP_RE);
			dim = longint'(RST_STEP_IM);
			thr = longint'(RST_THRESHOLD);
			limit = 32'(RST_MAX_ITERS);
			errors = 0;
		endfunction

		function longint clamp_s32(longint v);
			if (v > S32_HI) return S32_HI;
			if (v < S32_LO) return S32_LO;
			return v;
		endfunction

		// Floor of the Q4.28 product; arithmetic shift rounds toward minus infinity.
		function longint fixmul(longint a, longint b);
			return (a * b) >>> FRAC;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
			case (idx)
				REG_RE_MIN:    re0 = longint'($signed(data));
				REG_IM_MIN:    im0 = longint'($signed(data));
				REG_STEP_RE:   dre = longint'($signed(data));
				REG_STEP_IM:   dim = longint'($signed(data));
				REG_THRESHOLD: thr = longint'(data[THR_W-1:0]);
				REG_MAX_ITERS: limit = 32'(data[ITER_W-1:0]);
				default: ;
			endcase
		endfunction

		function met_out_t escape_counts(met_in_t g);
			longint cre[OUT_LANES], zr[OUT_LANES], zi[OUT_LANES];
			int unsigned cnt[OUT_LANES];
			bit live[OUT_LANES];
			longint cim, tr, ti;
			bit any;
			met_out_t r;
			cim = clamp_s32(im0 + dim * longint'(g.row));
			for (int k = 0; k < OUT_LANES; k++) begin
				cre[k] = clamp_s32(re0 + dre * (longint'(g.col_group) * OUT_LANES + k));
				zr[k] = 0;
				zi[k] = 0;
				cnt[k] = 0;
				live[k] = 1'b1;
			end
			for (int unsigned it = 0; it < limit; it++) begin
				any = 1'b0;
				for (int k = 0; k < OUT_LANES; k++) begin
					if (live[k]) begin
						tr = clamp_s32(clamp_s32(fixmul(zr[k], zr[k]))
							- clamp_s32(fixmul(zi[k], zi[k])));
						tr = clamp_s32(tr + cre[k]);
						ti = clamp_s32(fixmul(zr[k], zi[k]));
						ti = clamp_s32(clamp_s32(2 * ti) + cim);
						// magnitude stays unsaturated so the compare is exact
						if (fixmul(tr, tr) + fixmul(ti, ti) < thr) begin
							cnt[k]++;
							zr[k] = tr;
							zi[k] = ti;
							any = 1'b1;
						end else begin
							live[k] = 1'b0;
						end
					end
				end
				if (!any) break;
			end
			r.count0 = cnt[0][CNT_W-1:0];
			r.count1 = cnt[1][CNT_W-1:0];
			r.count2 = cnt[2][CNT_W-1:0];
			r.count3 = cnt[3][CNT_W-1:0];
			return r;
		endfunction

		function void note_group(met_in_t g);
			pending.push_back(escape_counts(g));
		endfunction

		function void check_counts(met_out_t got);
			met_out_t want;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("result %h with no group pending", got);
				return;
			end
			want = pending.pop_front();
			if (got.count0 !== want.count0 || got.count1 !== want.count1 ||
				got.count2 !== want.count2 || got.count3 !== want.count3) begin
				errors++;
				if (errors <= 10)
					$display("lane counts mismatch: expected %0d %0d %0d %0d, got %0d %0d %0d %0d",
						want.count0, want.count1, want.count2, want.count3,
						got.count0, got.count1, got.count2, got.count3);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	met_in_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	met_out_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	bit quiet = 1'b0;
	lane_count_book book = new();

	mandelbrot_escape_time_4lane u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		out_stall <= !quiet && ($urandom_range(0, 99) < 13);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) book.note_group(in_data);
			if (out_valid && !out_stall) book.check_counts(out_data);
		end
	end

	function automatic met_in_t grp(int c, int r);
		met_in_t g;
		g.col_group = 10'(c);
		g.row = 12'(r);
		return g;
	endfunction

	function automatic met_cfg_t view(logic [31:0] re, logic [31:0] im, logic [31:0] sr,
		logic [31:0] si, logic [THR_W-1:0] thr, logic [ITER_W-1:0] mi);
		met_cfg_t v;
		v.re_min = re;
		v.im_min = im;
		v.step_re = sr;
		v.step_im = si;
		v.threshold = thr;
		v.max_iters = mi;
		return v;
	endfunction

	// Window around the set, small iteration limits to keep groups short.
	function automatic met_cfg_t framed_view();
		met_cfg_t v;
		int mag;
		v.re_min = $urandom_range(0, ONE) - 5 * ONE / 2;
		v.im_min = $urandom_range(0, ONE) - 3 * ONE / 2;
		mag = $urandom_range(1 << 14, 1 << 19);
		v.step_re = ($urandom_range(0, 3) == 0) ? -mag : mag;
		mag = $urandom_range(1 << 14, 1 << 19);
		v.step_im = ($urandom_range(0, 3) == 0) ? -mag : mag;
		v.threshold = THR_W'(($urandom_range(0, 2) == 0) ?
			$urandom_range(ONE, 32'h7fffffff) : 4 * ONE);
		v.max_iters = ITER_W'($urandom_range(0, 24));
		return v;
	endfunction

	function automatic met_cfg_t noisy_view();
		met_cfg_t v;
		v.re_min = $urandom;
		v.im_min = $urandom;
		v.step_re = $signed($urandom) >>> $urandom_range(0, 24);
		v.step_im = $signed($urandom) >>> $urandom_range(0, 24);
		v.threshold = THR_W'($urandom);
		v.max_iters = ITER_W'($urandom_range(0, 24));
		return v;
	endfunction

	// Leaves cfg_valid high; the caller drops it after the last beat.
	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		book.set_reg(idx, val);
	endtask

	task automatic load_view(input met_cfg_t v, input bit spare);
		logic [31:0] junk;
		junk = $urandom;
		if (spare) put_reg(REG_SPARE, $urandom);
		put_reg(REG_RE_MIN, v.re_min);
		put_reg(REG_IM_MIN, v.im_min);
		put_reg(REG_STEP_RE, v.step_re);
		put_reg(REG_STEP_IM, v.step_im);
		// unused upper bits carry noise
		put_reg(REG_THRESHOLD, {junk[31], v.threshold});
		put_reg(REG_MAX_ITERS, {junk[31:16], v.max_iters});
		cfg_valid <= 1'b0;
	endtask

	task automatic send_group(input met_in_t g);
		if (!quiet && $urandom_range(0, 99) < 13) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= g;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (book.pending.size() != 0) @(posedge clk);
	endtask

	initial begin
		met_cfg_t v;
		int n;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// reset view: corners, the origin and points deep inside the set
		send_group(grp(0, 0));
		send_group(grp(1023, 4095));
		send_group(grp(512, 1024));
		send_group(grp(384, 1024));
		send_group(grp(400, 1300));
		send_group(grp(0, 4095));
		send_group(grp(1023, 0));
		send_group(grp(300, 900));
		drain();

		// counts past 255 wrap to their low byte
		load_view(view(0, 0, 1, 1, RST_THRESHOLD, 300), 1'b0);
		send_group(grp(0, 0));
		send_group(grp(1023, 4095));
		send_group(grp(5, 7));
		drain();

		// zero iteration limit
		load_view(view(-ONE, ONE / 2, 1 << 20, -(1 << 20), RST_THRESHOLD, 0), 1'b0);
		send_group(grp(0, 0));
		send_group(grp(1023, 4095));
		drain();

		// zero threshold with the largest limit
		load_view(view(RST_RE_MIN, RST_IM_MIN, RST_STEP_RE, RST_STEP_IM, 0, 16'hffff), 1'b0);
		send_group(grp(512, 1024));
		send_group(grp(1023, 4095));
		drain();

		// saturated coordinates at both range edges
		load_view(view(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
			31'h7fffffff, 16'hffff), 1'b0);
		send_group(grp(0, 0));
		send_group(grp(1023, 4095));
		send_group(grp(1, 1));
		drain();
		load_view(view(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
			31'h7fffffff, 16'hffff), 1'b0);
		send_group(grp(0, 0));
		send_group(grp(1023, 4095));
		drain();

		// c = -2: magnitude equals the threshold exactly, then one step above it
		load_view(view(-2 * ONE, 0, 0, 0, THR_W'(4 * ONE), 20), 1'b0);
		send_group(grp(7, 9));
		drain();
		load_view(view(-2 * ONE, 0, 0, 0, THR_W'(4 * ONE + 1), 20), 1'b0);
		send_group(grp(7, 9));
		drain();

		for (int p = 0; p < 14; p++) begin
			if (p == 3) begin
				v = view(RST_RE_MIN, RST_IM_MIN, RST_STEP_RE, RST_STEP_IM,
					RST_THRESHOLD, RST_MAX_ITERS);
				n = 30;
			end else if (p == 6) begin
				// imaginary part pinned high: every lane escapes on its first step
				v = noisy_view();
				v.im_min = 32'h7fffffff;
				v.step_im = $urandom_range(0, 32'h7fffffff);
				v.max_iters = 16'hffff;
				n = 30;
			end else begin
				v = (p % 4 == 1) ? noisy_view() : framed_view();
				n = 132;
			end
			quiet <= (p == 0);
			load_view(v, p % 4 == 1);
			for (int i = 0; i < n; i++) begin
				if (p == 3)
					send_group(grp($urandom_range(256, 640), $urandom_range(512, 1536)));
				else
					send_group(grp($urandom_range(0, 1023), $urandom_range(0, 4095)));
			end
			drain();
		end

		repeat (32) @(posedge clk);
		if (book.pending.size() != 0) book.errors++;
		if (book.errors == 0)
			$display("[mandelbrot_escape_time_4lane] OK");
		else
			$display("[mandelbrot_escape_time_4lane] ERROR");
		$finish;
	end

	initial begin
		#100_000_000;
		$display("[mandelbrot_escape_time_4lane] ERROR");
		$finish;
	end

endmodule
